>>> src/tcw_pkg.sv
// Shared codes, control/status structs and a saturating-add helper for the congestion window block.
package tcw_pkg;

  localparam logic [1:0] CMD_NEW_ACK = 2'd0;
  localparam logic [1:0] CMD_DUP_ACK = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [1:0] PHASE_SS = 2'd0;
  localparam logic [1:0] PHASE_CA = 2'd1;
  localparam logic [1:0] PHASE_FR = 2'd2;

  localparam logic [1:0] MODE_TAHOE = 2'd0;

  localparam logic CFG_MODE      = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic [2:0] NOTE_SS_GROW    = 3'd0;
  localparam logic [2:0] NOTE_ADDITIVE   = 3'd1;
  localparam logic [2:0] NOTE_EXIT_FR    = 3'd2;
  localparam logic [2:0] NOTE_DUP_WAIT   = 3'd3;
  localparam logic [2:0] NOTE_TAHOE      = 3'd4;
  localparam logic [2:0] NOTE_ENTER_FR   = 3'd5;
  localparam logic [2:0] NOTE_DUP_IGNORE = 3'd6;
  localparam logic [2:0] NOTE_INFLATE_TO = 3'd7;

  localparam logic [7:0] DUP_MAX     = 8'd255;
  localparam logic [7:0] DUP_TRIGGER = 8'd3;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic div_step;
    logic commit;
  } tcw_cmd_t;

  typedef struct packed {
    logic in_live;
    logic need_div;
    logic div_done;
    logic out_free;
  } tcw_stat_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> src/tcp_congestion_window_control.sv
// Top level of the TCP congestion window controller (Tahoe / Reno loss reaction).
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | cmd, ack_number
//  out      | out_valid / out_ready| event_index, event_echo, ack_echo, window_now,
//           |                      | threshold_now, phase_now, note_code, was_timeout
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  A new ACK in congestion avoidance runs through the radix-2 reciprocal divider,
//  which produces one quotient bit per cycle.
//  Every other request goes through intake then commit; drop an unused command at intake.
//  There is no clearing pass at reset.
//  The result register holds while out_ready is low; commit of the next request
//  waits for the slot, and in_ready stays low meanwhile.
module tcp_congestion_window_control import tcw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] ack_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] event_index,
  output logic [1:0]  event_echo,
  output logic [31:0] ack_echo,
  output logic [31:0] window_now,
  output logic [31:0] threshold_now,
  output logic [1:0]  phase_now,
  output logic [2:0]  note_code,
  output logic        was_timeout
);

  tcw_cmd_t  ctrl;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  tcw_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .ack_number    (ack_number),
    .out_ready     (out_ready),
    .ctrl          (ctrl),
    .stat          (stat),
    .out_valid     (out_valid),
    .event_index   (event_index),
    .event_echo    (event_echo),
    .ack_echo      (ack_echo),
    .window_now    (window_now),
    .threshold_now (threshold_now),
    .phase_now     (phase_now),
    .note_code     (note_code),
    .was_timeout   (was_timeout)
  );

endmodule

>>> src/tcw_ctrl.sv
// Controller state machine: request intake, divider sequencing and result commit.
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tcw_stat_t stat,
  output tcw_cmd_t  ctrl
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          if (stat.in_live) begin
            if (stat.need_div) begin
              ctrl.div_start = 1'b1;
              state_next     = ST_DIV;
            end else begin
              state_next = ST_COMMIT;
            end
          end
        end
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          ctrl.commit = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/tcw_dp.sv
// Datapath: window state, radix-2 reciprocal divider, configuration and result register.
module tcw_dp import tcw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  cmd,
  input  logic [31:0] ack_number,
  input  logic        out_ready,
  input  tcw_cmd_t    ctrl,
  output tcw_stat_t   stat,
  output logic        out_valid,
  output logic [31:0] event_index,
  output logic [1:0]  event_echo,
  output logic [31:0] ack_echo,
  output logic [31:0] window_now,
  output logic [31:0] threshold_now,
  output logic [1:0]  phase_now,
  output logic [2:0]  note_code,
  output logic        was_timeout
);

  localparam logic [31:0] FIX_ONE     = 32'(1) << FRAC_BITS;
  localparam logic [31:0] FIX_TWO     = 32'(2) << FRAC_BITS;
  localparam logic [31:0] FIX_THREE   = 32'(3) << FRAC_BITS;
  localparam logic [31:0] FIX_SIXTEEN = 32'(16) << FRAC_BITS;
  localparam int          DIV_STEPS   = 2 * FRAC_BITS + 1;
  localparam int          CNT_W       = $clog2(DIV_STEPS);

  logic [1:0]       mode;
  logic [31:0]      window;
  logic [31:0]      threshold;
  logic [1:0]       phase;
  logic [7:0]       dup_count;
  logic [31:0]      event_counter;
  logic [1:0]       cmd_q;
  logic [31:0]      ack_q;
  logic [31:0]      rem;
  logic [31:0]      quot;
  logic [CNT_W-1:0] div_cnt;

  logic [31:0] window_next;
  logic [31:0] threshold_next;
  logic [1:0]  phase_next;
  logic [7:0]  dup_next;
  logic [31:0] counter_next;
  logic [31:0] ack_next;
  logic [2:0]  note_next;
  logic        timeout_next;
  logic [7:0]  dup_inc;
  logic [31:0] half_win;
  logic [31:0] thr_halved;
  logic [31:0] ss_window;
  logic        tahoe;
  logic        shift_bit;
  logic [33:0] trial;
  logic        fits;
  logic [31:0] rem_next;

  // one quotient bit per step; dividend is a single one followed by 2*FRAC_BITS zeros
  assign shift_bit = (div_cnt == '0);
  assign trial     = {1'b0, rem, shift_bit} - {2'b00, window};
  assign fits      = !trial[33];
  assign rem_next  = fits ? trial[31:0] : {rem[30:0], shift_bit};

  assign stat.in_live  = (cmd != CMD_NONE);
  assign stat.need_div = (cmd == CMD_NEW_ACK) && (phase == PHASE_CA);
  assign stat.div_done = (div_cnt == CNT_W'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid || out_ready;

  assign tahoe      = (mode == MODE_TAHOE);
  assign dup_inc    = (dup_count == DUP_MAX) ? dup_count : dup_count + 8'd1;
  assign half_win   = window >> 1;
  assign thr_halved = (half_win < FIX_TWO) ? FIX_TWO : half_win;
  assign ss_window  = sat_add(window, FIX_ONE);

  always_comb begin
    window_next    = window;
    threshold_next = threshold;
    phase_next     = phase;
    dup_next       = dup_count;
    counter_next   = event_counter + 32'd1;
    ack_next       = ack_q;
    note_next      = NOTE_SS_GROW;
    timeout_next   = 1'b0;
    case (cmd_q)
      CMD_NEW_ACK: begin
        dup_next = '0;
        if (phase == PHASE_SS) begin
          window_next = ss_window;
          if (ss_window >= threshold) begin
            phase_next = PHASE_CA;
          end
          note_next = NOTE_SS_GROW;
        end else if (phase == PHASE_CA) begin
          window_next = sat_add(window, quot);
          note_next   = NOTE_ADDITIVE;
        end else begin
          window_next = threshold;
          phase_next  = PHASE_CA;
          note_next   = NOTE_EXIT_FR;
        end
      end
      CMD_DUP_ACK: begin
        dup_next = dup_inc;
        if (dup_inc < DUP_TRIGGER) begin
          note_next = NOTE_DUP_WAIT;
        end else if (dup_inc == DUP_TRIGGER) begin
          threshold_next = thr_halved;
          if (tahoe) begin
            window_next = FIX_ONE;
            phase_next  = PHASE_SS;
            note_next   = NOTE_TAHOE;
          end else begin
            window_next = sat_add(thr_halved, FIX_THREE);
            phase_next  = PHASE_FR;
            note_next   = NOTE_ENTER_FR;
          end
        end else if (tahoe) begin
          note_next = NOTE_DUP_IGNORE;
        end else begin
          window_next = ss_window;
          note_next   = NOTE_INFLATE_TO;
        end
      end
      CMD_TIMEOUT: begin
        threshold_next = thr_halved;
        window_next    = FIX_ONE;
        dup_next       = '0;
        phase_next     = PHASE_SS;
        note_next      = NOTE_INFLATE_TO;
        timeout_next   = 1'b1;
        ack_next       = '0;
      end
      default: begin
        counter_next = event_counter;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_TAHOE;
      window        <= FIX_ONE;
      threshold     <= FIX_SIXTEEN;
      phase         <= PHASE_SS;
      dup_count     <= '0;
      event_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: begin
            mode <= cfg_data[1:0];
          end
          CFG_THRESHOLD: begin
            threshold <= (cfg_data < FIX_ONE) ? FIX_ONE : cfg_data;
          end
          default: begin
            mode <= mode;
          end
        endcase
      end
      if (ctrl.commit) begin
        window        <= window_next;
        threshold     <= threshold_next;
        phase         <= phase_next;
        dup_count     <= dup_next;
        event_counter <= counter_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_q <= cmd;
      ack_q <= ack_number;
    end
    if (ctrl.div_start) begin
      rem     <= '0;
      quot    <= '0;
      div_cnt <= '0;
    end else if (ctrl.div_step) begin
      rem     <= rem_next;
      quot    <= {quot[30:0], fits};
      div_cnt <= div_cnt + CNT_W'(1);
    end
    if (ctrl.commit) begin
      event_index   <= counter_next;
      event_echo    <= cmd_q;
      ack_echo      <= ack_next;
      window_now    <= window_next;
      threshold_now <= threshold_next;
      phase_now     <= phase_next;
      note_code     <= note_next;
      was_timeout   <= timeout_next;
    end
  end

endmodule

>>> src/tcw_checker.sv
// Port-level assertion checker for the congestion window controller, with its bind.
module tcw_checker import tcw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] event_index,
  input logic [1:0]  event_echo,
  input logic [31:0] ack_echo,
  input logic [31:0] window_now,
  input logic [1:0]  phase_now,
  input logic [2:0]  note_code,
  input logic        was_timeout
);

  localparam logic [31:0] FIX_ONE = 32'(1) << FRAC_BITS;

  logic [31:0] last_index;
  logic        seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_index <= event_index;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_now) && $stable(event_index))
    else $error("stalled result changed");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && seen |-> event_index == last_index + 32'd1)
    else $error("event index skipped or repeated");

  a_timeout_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_timeout |-> window_now == FIX_ONE && phase_now == PHASE_SS &&
      ack_echo == 32'd0 && event_echo == CMD_TIMEOUT && note_code == NOTE_INFLATE_TO)
    else $error("malformed timeout record");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd != CMD_NONE |=> !in_ready)
    else $error("second request taken while one is in work");

endmodule

bind tcp_congestion_window_control tcw_checker #(.FRAC_BITS(FRAC_BITS)) u_tcw_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the TCP congestion window controller.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int          FRAC         = 16;
  localparam logic [31:0] FIX_ONE      = 32'h0001_0000;
  localparam logic [31:0] FIX_TWO      = 32'h0002_0000;
  localparam logic [31:0] FIX_THREE    = 32'h0003_0000;
  localparam logic [1:0]  MODE_RENO    = 2'd1;
  localparam logic [1:0]  MODE_NEWRENO = 2'd2;
  localparam logic [1:0]  MODE_SPARE   = 2'd3;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          SEGMENTS     = 9;
  localparam int          SEG_QUOTA    = 150;

  typedef struct packed {
    logic [31:0] evt_index;
    logic [1:0]  kind;
    logic [31:0] ack;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [1:0]  stage;
    logic [2:0]  note;
    logic        timed_out;
  } trace_t;

  class cwnd_tracker;
    logic [1:0]  mode;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [1:0]  stage;
    logic [7:0]  dups;
    logic [31:0] events;
    trace_t      pending_traces[$];
    int          errors;

    function new();
      mode     = MODE_TAHOE;
      cwnd     = FIX_ONE;
      ssthresh = 32'h0010_0000;
      stage    = PHASE_SS;
      dups     = '0;
      events   = '0;
      errors   = 0;
    endfunction

    function int outstanding();
      return pending_traces.size();
    endfunction

    function logic [31:0] grow(logic [31:0] a, logic [31:0] b);
      logic [31:0] s;
      s = a + b;
      if (s < a) s = 32'hFFFF_FFFF;
      return s;
    endfunction

    function logic [31:0] halved(logic [31:0] w);
      logic [31:0] h;
      h = w >> 1;
      return (h < FIX_TWO) ? FIX_TWO : h;
    endfunction

    function void apply_register(logic idx, logic [31:0] v);
      if (idx == CFG_MODE) begin
        mode = v[1:0];
      end else begin
        ssthresh = (v < FIX_ONE) ? FIX_ONE : v;
      end
    endfunction

    function void note_event(logic [1:0] c, logic [31:0] a);
      trace_t      t;
      logic [63:0] inc;
      if (c == CMD_NONE) return;
      events = events + 32'd1;
      t = '0;
      t.kind = c;
      t.ack = a;
      case (c)
        CMD_NEW_ACK: begin
          dups = '0;
          if (stage == PHASE_SS) begin
            cwnd = grow(cwnd, FIX_ONE);
            if (cwnd >= ssthresh) stage = PHASE_CA;
            t.note = NOTE_SS_GROW;
          end else if (stage == PHASE_CA) begin
            inc = (cwnd != 0) ? ((64'd1 << (2 * FRAC)) / {32'd0, cwnd}) : 64'd0;
            if (inc > 64'hFFFF_FFFF) inc = 64'hFFFF_FFFF;
            cwnd = grow(cwnd, inc[31:0]);
            t.note = NOTE_ADDITIVE;
          end else begin
            cwnd = ssthresh;
            stage = PHASE_CA;
            t.note = NOTE_EXIT_FR;
          end
        end
        CMD_DUP_ACK: begin
          if (dups != DUP_MAX) dups = dups + 8'd1;
          if (dups < DUP_TRIGGER) begin
            t.note = NOTE_DUP_WAIT;
          end else if (dups == DUP_TRIGGER) begin
            ssthresh = halved(cwnd);
            if (mode == MODE_TAHOE) begin
              cwnd = FIX_ONE;
              stage = PHASE_SS;
              t.note = NOTE_TAHOE;
            end else begin
              cwnd = grow(ssthresh, FIX_THREE);
              stage = PHASE_FR;
              t.note = NOTE_ENTER_FR;
            end
          end else if (mode == MODE_TAHOE) begin
            t.note = NOTE_DUP_IGNORE;
          end else begin
            cwnd = grow(cwnd, FIX_ONE);
            t.note = NOTE_INFLATE_TO;
          end
        end
        default: begin
          ssthresh = halved(cwnd);
          cwnd = FIX_ONE;
          dups = '0;
          stage = PHASE_SS;
          t.note = NOTE_INFLATE_TO;
          t.timed_out = 1'b1;
          t.ack = '0;
        end
      endcase
      t.evt_index = events;
      t.cwnd = cwnd;
      t.ssthresh = ssthresh;
      t.stage = stage;
      pending_traces.push_back(t);
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_trace(trace_t got);
      trace_t want;
      if (pending_traces.size() == 0) begin
        flag_mismatch("unexpected result, index", got.evt_index, 32'd0);
        return;
      end
      want = pending_traces.pop_front();
      if (got.evt_index !== want.evt_index)
        flag_mismatch("event_index", got.evt_index, want.evt_index);
      if (got.kind !== want.kind) flag_mismatch("event_echo", got.kind, want.kind);
      if (got.ack !== want.ack) flag_mismatch("ack_echo", got.ack, want.ack);
      if (got.cwnd !== want.cwnd) flag_mismatch("window_now", got.cwnd, want.cwnd);
      if (got.ssthresh !== want.ssthresh)
        flag_mismatch("threshold_now", got.ssthresh, want.ssthresh);
      if (got.stage !== want.stage) flag_mismatch("phase_now", got.stage, want.stage);
      if (got.note !== want.note) flag_mismatch("note_code", got.note, want.note);
      if (got.timed_out !== want.timed_out)
        flag_mismatch("was_timeout", got.timed_out, want.timed_out);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [31:0] ack_number;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] event_index;
  logic [1:0]  event_echo;
  logic [31:0] ack_echo;
  logic [31:0] window_now;
  logic [31:0] threshold_now;
  logic [1:0]  phase_now;
  logic [2:0]  note_code;
  logic        was_timeout;

  cwnd_tracker sb;
  int          send_idle;
  int          recv_idle;

  tcp_congestion_window_control u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .ack_number    (ack_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_index   (event_index),
    .event_echo    (event_echo),
    .ack_echo      (ack_echo),
    .window_now    (window_now),
    .threshold_now (threshold_now),
    .phase_now     (phase_now),
    .note_code     (note_code),
    .was_timeout   (was_timeout)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    trace_t got;
    if (!rst && out_valid && out_ready) begin
      got.evt_index = event_index;
      got.kind      = event_echo;
      got.ack       = ack_echo;
      got.cwnd      = window_now;
      got.ssthresh  = threshold_now;
      got.stage     = phase_now;
      got.note      = note_code;
      got.timed_out = was_timeout;
      sb.check_trace(got);
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_request(input logic [1:0] c, input logic [31:0] a);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    ack_number <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(c, a);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] m, input logic [31:0] thr);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= {30'd0, m};
    @(posedge clk);
    sb.apply_register(CFG_MODE, {30'd0, m});
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    sb.apply_register(CFG_THRESHOLD, thr);
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(input int quota, input bit long_dup_run);
    int          sent;
    int          r;
    int          n;
    logic [1:0]  c;
    sent = 0;
    if (long_dup_run) begin
      send_request(CMD_NEW_ACK, $urandom());
      repeat (260) send_request(CMD_DUP_ACK, $urandom());
    end
    while (sent < quota) begin
      r = $urandom_range(99);
      if (r < 35) begin
        n = $urandom_range(12, 1);
        repeat (n) send_request(CMD_NEW_ACK, $urandom());
        sent += n;
      end else if (r < 60) begin
        n = $urandom_range(6, 1);
        repeat (n) send_request(CMD_DUP_ACK, $urandom());
        send_request(CMD_NEW_ACK, $urandom());
        sent += n + 1;
      end else if (r < 70) begin
        n = $urandom_range(20, 4);
        repeat (n) send_request(CMD_DUP_ACK, $urandom());
        sent += n;
      end else if (r < 80) begin
        send_request(CMD_TIMEOUT, $urandom());
        sent++;
      end else if (r < 92) begin
        n = $urandom_range(5, 1);
        repeat (n) begin
          c = 2'($urandom_range(3, 0));
          send_request(c, $urandom());
          if (c != CMD_NONE) sent++;
        end
      end else begin
        send_request(CMD_NONE, $urandom());
      end
    end
  endtask

  initial begin
    logic [1:0]  m;
    logic [31:0] thr;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_MODE;
    cfg_data   = '0;
    in_valid   = 1'b0;
    cmd        = CMD_NEW_ACK;
    ack_number = '0;
    send_idle  = 10;
    recv_idle  = 48;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    configure(MODE_TAHOE, 32'h0000_0000);
    send_request(CMD_NEW_ACK, 32'h0000_0000);
    send_request(CMD_NEW_ACK, 32'hFFFF_FFFF);
    send_request(CMD_NONE, 32'hFFFF_FFFF);
    send_request(CMD_DUP_ACK, 32'h5555_5555);
    send_request(CMD_DUP_ACK, 32'hAAAA_AAAA);
    send_request(CMD_DUP_ACK, 32'h0000_0001);
    send_request(CMD_DUP_ACK, 32'h8000_0000);
    send_request(CMD_TIMEOUT, 32'hFFFF_FFFF);

    configure(MODE_SPARE, 32'h0003_0000);
    send_request(CMD_NEW_ACK, 32'h1234_5678);
    send_request(CMD_NEW_ACK, 32'h0000_0000);
    repeat (3) send_request(CMD_DUP_ACK, 32'hFFFF_FFFF);
    send_request(CMD_DUP_ACK, 32'h0000_0000);
    send_request(CMD_NEW_ACK, 32'h7FFF_FFFF);
    send_request(CMD_NEW_ACK, 32'hFFFF_FFFF);
    send_request(CMD_TIMEOUT, 32'h0000_0000);

    configure(MODE_RENO, 32'hFFFF_FFFF);
    send_request(CMD_NEW_ACK, 32'hDEAD_BEEF);
    repeat (4) send_request(CMD_DUP_ACK, 32'h0F0F_0F0F);
    send_request(CMD_TIMEOUT, 32'hF0F0_F0F0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin m = MODE_TAHOE;   thr = 32'h0010_0000; end
        1: begin m = MODE_RENO;    thr = 32'h0000_0000; end
        2: begin m = MODE_NEWRENO; thr = 32'hFFFF_FFFF; end
        3: begin m = MODE_SPARE;   thr = 32'h0001_0000; end
        4: begin m = MODE_TAHOE;   thr = 32'h0000_FFFF; end
        5: begin m = MODE_RENO;    thr = 32'h0002_0000; end
        6: begin m = MODE_NEWRENO; thr = $urandom(); end
        7: begin m = MODE_SPARE;   thr = 32'h0040_0000; end
        default: begin m = MODE_TAHOE; thr = $urandom_range(32'h0080_0000, 32'h0001_0000); end
      endcase
      configure(m, thr);
      send_idle = (seg < 3) ? 10 : (seg < 6) ? 48 : 0;
      recv_idle = (seg < 3) ? 48 : (seg < 6) ? 10 : 0;
      run_traffic(SEG_QUOTA, (seg == 1) || (seg == 4));
    end

    // drive the window to the top of its range through a recovery exit
    configure(MODE_RENO, 32'h0010_0000);
    send_request(CMD_NEW_ACK, $urandom());
    repeat (3) send_request(CMD_DUP_ACK, $urandom());
    configure(MODE_RENO, 32'hFFFF_FFFF);
    repeat (3) send_request(CMD_NEW_ACK, $urandom());
    repeat (5) send_request(CMD_DUP_ACK, $urandom());
    send_request(CMD_NEW_ACK, $urandom());
    settle();

    if (sb.outstanding() != 0)
      sb.flag_mismatch("results never arrived, count", sb.outstanding(), 32'd0);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
